// ===== design/glp_pkg.sv =====
// Shared constants, types and character helpers for the G-code line field parser.
`timescale 1ns / 1ps

package glp_pkg;

	localparam int FRACTION_DIGITS_DEF = 3;
	localparam int NUM_WORDS = 7;

	localparam logic [2:0]  NO_WORD  = 3'd7;
	localparam logic [31:0] MAG_MAX  = 32'h7FFF_FFFF;
	localparam logic [15:0] CODE_MAX = 16'hFFFF;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_G_LC  = 8'h67;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_M_LC  = 8'h6D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_F     = 8'h46;

	localparam logic [1:0] LETTER_NONE = 2'd0;
	localparam logic [1:0] LETTER_G    = 2'd1;
	localparam logic [1:0] LETTER_M    = 2'd2;

	typedef logic [31:0] word_t;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_INT   = 4'b0010,
		PH_FRAC  = 4'b0100,
		PH_DONE  = 4'b1000
	} num_phase_t;

	typedef struct packed {
		logic       char_en;
		logic       eol;
		logic       key_ok;
		logic [7:0] ch;
	} bank_ctl_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic [2:0] key_index(input logic [7:0] c);
		logic [2:0] k;
		case (c)
			CH_X:    k = 3'd0;
			CH_Y:    k = 3'd1;
			CH_Z:    k = 3'd2;
			CH_A:    k = 3'd3;
			CH_B:    k = 3'd4;
			CH_C:    k = 3'd5;
			CH_F:    k = 3'd6;
			default: k = NO_WORD;
		endcase
		return k;
	endfunction

	function automatic logic [19:0] pow10(input logic [2:0] n);
		logic [19:0] p;
		case (n)
			3'd0:    p = 20'd1;
			3'd1:    p = 20'd10;
			3'd2:    p = 20'd100;
			3'd3:    p = 20'd1000;
			3'd4:    p = 20'd10000;
			3'd5:    p = 20'd100000;
			3'd6:    p = 20'd1000000;
			default: p = 20'd0;
		endcase
		return p;
	endfunction

endpackage

// ===== design/glp_word_bank.sv =====
// Axis and feed word registers with the decimal number accumulator.
`timescale 1ns / 1ps

module glp_word_bank import glp_pkg::*; #(
	parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bank_ctl_t                     ctl,
	output logic                          num_take,
	output word_t [NUM_WORDS-1:0]         values,
	output logic [NUM_WORDS-1:0]          present
);

	localparam int FC_W = (FRACTION_DIGITS < 1) ? 1 : $clog2(FRACTION_DIGITS + 1);
	localparam logic [19:0] INT_SCALE = pow10(3'(FRACTION_DIGITS));

	word_t                wv_q [NUM_WORDS];
	logic [2:0]           active_q;
	num_phase_t           phase_q;
	logic                 neg_q;
	logic [FC_W-1:0]      fc_q;
	logic [NUM_WORDS-1:0] present_q;

	logic                 dig_c;
	logic                 num_char;
	logic                 open_c;
	logic                 close_en;
	word_t                sel;
	word_t                neg_sel;
	logic [3:0]           dig;
	logic [35:0]          int_sum;
	logic [35:0]          frac_sum;
	logic [35:0]          add_val;
	word_t                sat_val;
	logic [2:0]           frac_idx;
	logic                 frac_room;
	num_phase_t           phase_d;
	logic                 neg_d;
	logic                 add_int;
	logic                 add_frac;
	logic                 add_en;
	logic [FC_W-1:0]      fc_d;
	logic [2:0]           key_k;
	logic                 key_new;

	always_comb begin
		dig_c    = is_digit(ctl.ch);
		num_char = dig_c || (ctl.ch == CH_DOT) || (ctl.ch == CH_MINUS);
		open_c   = (active_q != NO_WORD);
		num_take = ctl.char_en && open_c && num_char;
		close_en = ctl.char_en && open_c && !num_char;

		sel = '0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			if (active_q == 3'(i))
				sel = wv_q[i];
		end
		neg_sel = -sel;

		dig       = ctl.ch[3:0];
		frac_idx  = 3'(FRACTION_DIGITS - 1 - int'(fc_q));
		frac_room = int'(fc_q) < FRACTION_DIGITS;
		int_sum   = 36'(sel) * 36'd10 + 36'(dig) * 36'(INT_SCALE);
		frac_sum  = 36'(sel) + 36'(dig) * 36'(pow10(frac_idx));

		phase_d  = phase_q;
		neg_d    = neg_q;
		add_int  = 1'b0;
		add_frac = 1'b0;
		unique case (phase_q)
			PH_START: begin
				if (ctl.ch == CH_MINUS) begin
					neg_d   = 1'b1;
					phase_d = PH_INT;
				end else if (ctl.ch == CH_DOT) begin
					phase_d = PH_FRAC;
				end else begin
					phase_d = PH_INT;
					add_int = 1'b1;
				end
			end
			PH_INT: begin
				if (dig_c)
					add_int = 1'b1;
				else if (ctl.ch == CH_DOT)
					phase_d = PH_FRAC;
				else
					phase_d = PH_DONE;
			end
			PH_FRAC: begin
				if (dig_c)
					add_frac = frac_room;
				else
					phase_d = PH_DONE;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		add_en  = add_int || add_frac;
		fc_d    = add_frac ? FC_W'(fc_q + 1'b1) : fc_q;
		add_val = add_int ? int_sum : frac_sum;
		sat_val = (add_val > 36'(MAG_MAX)) ? MAG_MAX : add_val[31:0];

		key_k   = key_index(ctl.ch);
		key_new = ctl.key_ok && (key_k != NO_WORD) && !present_q[key_k];

		for (int i = 0; i < NUM_WORDS; i++)
			values[i] = ((active_q == 3'(i)) && neg_q) ? neg_sel : wv_q[i];
		present = present_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= NO_WORD;
			phase_q   <= PH_START;
			neg_q     <= 1'b0;
			fc_q      <= '0;
			present_q <= '0;
			for (int i = 0; i < NUM_WORDS; i++)
				wv_q[i] <= '0;
		end else if (ctl.eol) begin
			active_q  <= NO_WORD;
			phase_q   <= PH_START;
			neg_q     <= 1'b0;
			fc_q      <= '0;
			present_q <= '0;
			for (int i = 0; i < NUM_WORDS; i++)
				wv_q[i] <= '0;
		end else begin
			if (num_take) begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				fc_q    <= fc_d;
				for (int i = 0; i < NUM_WORDS; i++) begin
					if (add_en && (active_q == 3'(i)))
						wv_q[i] <= sat_val;
				end
			end
			if (close_en) begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					if (neg_q && (active_q == 3'(i)))
						wv_q[i] <= neg_sel;
				end
				active_q <= NO_WORD;
				neg_q    <= 1'b0;
			end
			if (key_new) begin
				present_q[key_k] <= 1'b1;
				active_q         <= key_k;
				phase_q          <= PH_START;
				neg_q            <= 1'b0;
				fc_q             <= '0;
				for (int i = 0; i < NUM_WORDS; i++) begin
					if (key_k == 3'(i))
						wv_q[i] <= '0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_active_present: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q != NO_WORD) |-> present_q[active_q])
		else $error("open word without present bit");

	a_closed_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q == NO_WORD) |-> !neg_q)
		else $error("sign flag left set with no open word");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.eol |=> (active_q == NO_WORD) && (present_q == '0))
		else $error("word state not cleared at end of line");
`endif

endmodule

// ===== design/gcode_line_field_parser_core.sv =====
// Top level of the G-code line field parser: input register, line state, result register.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------------
//  in      | in_valid / in_stall | cmd, char_code
//  out     | out_valid/out_stall | line_valid, cmd_letter, cmd_code, x_value..c_value,
//          |                     | feed_value, present_mask
//
// One request per cycle while in_stall is low; a character is folded into the line state in
// the cycle after it is taken, and an end of line goes from the input register to the result
// register once that is free. The rate is set by the single decode/accumulate stage behind the
// input register. in_stall rises only while an end of line waits in the input register behind
// a held result. arst_n clears the line state, the word registers and both valid flags.
`timescale 1ns / 1ps

module gcode_line_field_parser_core import glp_pkg::*; #(
	parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         char_code,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               line_valid,
	output logic [1:0]         cmd_letter,
	output logic [15:0]        cmd_code,
	output logic signed [31:0] x_value,
	output logic signed [31:0] y_value,
	output logic signed [31:0] z_value,
	output logic signed [31:0] a_value,
	output logic signed [31:0] b_value,
	output logic signed [31:0] c_value,
	output logic signed [31:0] feed_value,
	output logic [6:0]         present_mask
);

	logic                 valid_s1;
	logic                 cmd_s1;
	logic [7:0]           char_s1;

	logic                 seen_q;
	logic                 comment_q;
	logic [1:0]           letter_q;
	logic [15:0]          code_q;
	logic                 code_run_q;

	logic                 res_valid_q;
	logic                 res_line_q;
	logic [1:0]           res_letter_q;
	logic [15:0]          res_code_q;
	word_t                res_vals_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] res_mask_q;

	logic                 out_ready;
	logic                 advance;
	logic                 char_en;
	logic                 eol_en;
	logic                 dig_c;
	logic                 num_take;
	logic                 code_take;
	logic                 gm_hit;
	logic                 line_ok;
	logic [19:0]          code_sum;
	logic [15:0]          code_sat;
	bank_ctl_t            bank_ctl;
	word_t [NUM_WORDS-1:0] bank_vals;
	logic [NUM_WORDS-1:0] bank_present;

	always_comb begin
		out_ready = !res_valid_q || !out_stall;
		advance   = valid_s1 && (!cmd_s1 || out_ready);
		in_stall  = valid_s1 && cmd_s1 && !out_ready;
		char_en   = advance && !cmd_s1;
		eol_en    = advance && cmd_s1;
		dig_c     = is_digit(char_s1);
		code_take = char_en && !num_take && code_run_q && dig_c;
		gm_hit    = char_en && !num_take && !code_take &&
			((char_s1 == CH_G) || (char_s1 == CH_G_LC) ||
			 (char_s1 == CH_M) || (char_s1 == CH_M_LC));
		code_sum  = 20'(code_q) * 20'd10 + 20'(char_s1[3:0]);
		code_sat  = (code_sum > 20'(CODE_MAX)) ? CODE_MAX : code_sum[15:0];
		line_ok   = seen_q && !comment_q;

		// key letters are never digits, '.', '-', G or M
		bank_ctl.char_en = char_en;
		bank_ctl.eol     = eol_en;
		bank_ctl.key_ok  = char_en;
		bank_ctl.ch      = char_s1;
	end

	glp_word_bank #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_word_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (bank_ctl),
		.num_take (num_take),
		.values   (bank_vals),
		.present  (bank_present)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1  <= cmd;
			char_s1 <= char_code;
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 1'b0;
			comment_q  <= 1'b0;
			letter_q   <= LETTER_NONE;
			code_q     <= '0;
			code_run_q <= 1'b0;
		end else if (eol_en) begin
			seen_q     <= 1'b0;
			comment_q  <= 1'b0;
			letter_q   <= LETTER_NONE;
			code_q     <= '0;
			code_run_q <= 1'b0;
		end else if (char_en) begin
			if (!seen_q && !is_blank(char_s1)) begin
				seen_q    <= 1'b1;
				comment_q <= (char_s1 == CH_SEMI);
			end
			if (code_take) begin
				code_q <= code_sat;
			end else if (gm_hit) begin
				letter_q   <= ((char_s1 == CH_G) || (char_s1 == CH_G_LC)) ? LETTER_G : LETTER_M;
				code_q     <= '0;
				code_run_q <= 1'b1;
			end else if (!num_take) begin
				code_run_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (eol_en) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eol_en) begin
			res_line_q   <= line_ok;
			res_letter_q <= line_ok ? letter_q : LETTER_NONE;
			res_code_q   <= line_ok ? code_q : '0;
			res_mask_q   <= line_ok ? bank_present : '0;
			for (int i = 0; i < NUM_WORDS; i++)
				res_vals_q[i] <= line_ok ? bank_vals[i] : '0;
		end
	end

	assign out_valid    = res_valid_q;
	assign line_valid   = res_line_q;
	assign cmd_letter   = res_letter_q;
	assign cmd_code     = res_code_q;
	assign x_value      = res_vals_q[0];
	assign y_value      = res_vals_q[1];
	assign z_value      = res_vals_q[2];
	assign a_value      = res_vals_q[3];
	assign b_value      = res_vals_q[4];
	assign c_value      = res_vals_q[5];
	assign feed_value   = res_vals_q[6];
	assign present_mask = res_mask_q;

`ifndef SYNTHESIS
	a_eol_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		eol_en |=> out_valid)
		else $error("end of line did not produce a result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !line_valid) |->
			(present_mask == '0) && (cmd_code == '0) && (cmd_letter == LETTER_NONE))
		else $error("invalid line carries nonzero fields");

	a_code_needs_letter: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (cmd_letter == LETTER_NONE)) |-> (cmd_code == '0))
		else $error("command code without command letter");

	a_eol_clears_line: assert property (@(posedge clk) disable iff (!arst_n)
		eol_en |=> !seen_q && !code_run_q && (letter_q == LETTER_NONE))
		else $error("line state not cleared after end of line");
`endif

endmodule

// ===== tb/gcode_line_checker.sv =====
// Checker for the G-code line parser: line-state predictor and result scoreboard.
`timescale 1ns / 1ps

module gcode_line_checker import glp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               cmd,
	input  logic [7:0]         char_code,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               line_valid,
	input  logic [1:0]         cmd_letter,
	input  logic [15:0]        cmd_code,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic signed [31:0] z_value,
	input  logic signed [31:0] a_value,
	input  logic signed [31:0] b_value,
	input  logic signed [31:0] c_value,
	input  logic signed [31:0] feed_value,
	input  logic [6:0]         present_mask,
	output int                 mismatches,
	output int                 lines_waiting,
	output int                 lines_checked,
	output int                 valid_lines
);

	localparam logic [NUM_WORDS-1:0][7:0] AXIS_KEY = {CH_F, CH_C, CH_B, CH_A, CH_Z, CH_Y, CH_X};
	localparam logic [7:0] LC_FIRST = "a";
	localparam logic [7:0] LC_LAST  = "z";

	typedef struct packed {
		logic                       ok;
		logic [1:0]                 letter;
		logic [15:0]                code;
		logic [NUM_WORDS-1:0][31:0] vals;
		logic [6:0]                 mask;
	} line_result_t;

	line_result_t expected_lines[$];

	// line state
	logic                       ink_seen;
	logic                       comment_seen;
	logic                       code_open;
	logic                       minus_seen;
	logic [1:0]                 letter_now;
	logic [15:0]                code_now;
	logic [2:0]                 open_word;
	num_phase_t                 num_phase;
	int                         frac_taken;
	logic [NUM_WORDS-1:0][31:0] word_mag;
	logic [6:0]                 words_seen;

	task automatic clear_line();
		ink_seen     = 1'b0;
		comment_seen = 1'b0;
		code_open    = 1'b0;
		minus_seen   = 1'b0;
		letter_now   = LETTER_NONE;
		code_now     = '0;
		open_word    = NO_WORD;
		num_phase    = PH_START;
		frac_taken   = 0;
		word_mag     = '0;
		words_seen   = '0;
	endtask

	function automatic logic [63:0] decimal_scale(input int n);
		logic [63:0] p;
		p = 64'd1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	function automatic logic numeral(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	task automatic take_digit(input logic [7:0] c);
		logic [63:0] m;
		logic [63:0] d;
		m = {32'd0, word_mag[open_word]};
		d = {56'd0, c - CH_0};
		if (num_phase == PH_INT) begin
			m = m * 10 + d * decimal_scale(FRACTION_DIGITS_DEF);
		end else begin
			if (frac_taken >= FRACTION_DIGITS_DEF)
				return;
			frac_taken++;
			m = m + d * decimal_scale(FRACTION_DIGITS_DEF - frac_taken);
		end
		if (m > {32'd0, MAG_MAX})
			m = {32'd0, MAG_MAX};
		word_mag[open_word] = m[31:0];
	endtask

	task automatic take_number(input logic [7:0] c);
		case (num_phase)
			PH_START: begin
				if (c == CH_MINUS) begin
					minus_seen = 1'b1;
					num_phase  = PH_INT;
				end else if (c == CH_DOT) begin
					num_phase = PH_FRAC;
				end else begin
					num_phase = PH_INT;
					take_digit(c);
				end
			end
			PH_INT: begin
				if (numeral(c))
					take_digit(c);
				else if (c == CH_DOT)
					num_phase = PH_FRAC;
				else
					num_phase = PH_DONE;
			end
			PH_FRAC: begin
				if (numeral(c))
					take_digit(c);
				else
					num_phase = PH_DONE;
			end
			default: ;
		endcase
	endtask

	// magnitude becomes a signed value once the run ends
	task automatic close_word();
		if (open_word != NO_WORD && minus_seen)
			word_mag[open_word] = -word_mag[open_word];
		open_word  = NO_WORD;
		minus_seen = 1'b0;
	endtask

	task automatic take_char(input logic [7:0] c);
		logic [7:0]  up;
		logic [31:0] wide;
		if (!ink_seen && !(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
			ink_seen = 1'b1;
			if (c == CH_SEMI)
				comment_seen = 1'b1;
		end
		if (open_word != NO_WORD) begin
			if (numeral(c) || c == CH_DOT || c == CH_MINUS) begin
				take_number(c);
				return;
			end
			close_word();
		end
		if (code_open) begin
			if (numeral(c)) begin
				wide = {16'd0, code_now} * 10 + {24'd0, c - CH_0};
				code_now = (wide > {16'd0, CODE_MAX}) ? CODE_MAX : wide[15:0];
				return;
			end
			code_open = 1'b0;
		end
		up = (c >= LC_FIRST && c <= LC_LAST) ? c - 8'd32 : c;
		if (up == CH_G || up == CH_M) begin
			letter_now = (up == CH_G) ? LETTER_G : LETTER_M;
			code_now   = '0;
			code_open  = 1'b1;
			return;
		end
		for (int k = 0; k < NUM_WORDS; k++) begin
			if (c == AXIS_KEY[k] && !words_seen[k]) begin
				words_seen[k] = 1'b1;
				open_word     = 3'(k);
				num_phase     = PH_START;
				minus_seen    = 1'b0;
				frac_taken    = 0;
				word_mag[k]   = '0;
			end
		end
	endtask

	task automatic end_line(output line_result_t r);
		close_word();
		r = '0;
		if (ink_seen && !comment_seen) begin
			r.ok     = 1'b1;
			r.letter = letter_now;
			r.code   = code_now;
			r.vals   = word_mag;
			r.mask   = words_seen;
		end
		clear_line();
	endtask

	task automatic match_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: line %0d %s expected %0d (0x%h) got %0d (0x%h)",
					lines_checked, what, $signed(want), want, $signed(got), got);
		end
	endtask

	initial begin
		mismatches    = 0;
		lines_waiting = 0;
		lines_checked = 0;
		valid_lines   = 0;
		clear_line();
	end

	always @(posedge clk) begin
		line_result_t got_line;
		line_result_t want_line;
		line_result_t new_line;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got_line.ok     = line_valid;
				got_line.letter = cmd_letter;
				got_line.code   = cmd_code;
				got_line.vals   = {feed_value, c_value, b_value, a_value, z_value, y_value,
					x_value};
				got_line.mask   = present_mask;
				if (expected_lines.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: line result with none expected");
				end else begin
					want_line = expected_lines.pop_front();
					match_field("line_valid", 32'(got_line.ok), 32'(want_line.ok));
					match_field("cmd_letter", 32'(got_line.letter), 32'(want_line.letter));
					match_field("cmd_code", 32'(got_line.code), 32'(want_line.code));
					match_field("x_value", got_line.vals[0], want_line.vals[0]);
					match_field("y_value", got_line.vals[1], want_line.vals[1]);
					match_field("z_value", got_line.vals[2], want_line.vals[2]);
					match_field("a_value", got_line.vals[3], want_line.vals[3]);
					match_field("b_value", got_line.vals[4], want_line.vals[4]);
					match_field("c_value", got_line.vals[5], want_line.vals[5]);
					match_field("feed_value", got_line.vals[6], want_line.vals[6]);
					match_field("present_mask", 32'(got_line.mask), 32'(want_line.mask));
					lines_checked++;
					if (want_line.ok)
						valid_lines++;
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd) begin
					end_line(new_line);
					expected_lines.push_back(new_line);
				end else begin
					take_char(char_code);
				end
			end
			lines_waiting = expected_lines.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the G-code line parser: clock, reset, character stimulus, verdict.
`timescale 1ns / 1ps

module tb;
	import glp_pkg::*;

	localparam logic [NUM_WORDS-1:0][7:0] AXIS_KEY = {CH_F, CH_C, CH_B, CH_A, CH_Z, CH_Y, CH_X};
	localparam int TARGET_REQUESTS = 500;
	localparam int TARGET_LINES    = 40;
	localparam int LONG_HOLD       = 60;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               cmd;
	logic [7:0]         char_code;
	logic               out_valid;
	logic               out_stall;
	logic               line_valid;
	logic [1:0]         cmd_letter;
	logic [15:0]        cmd_code;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic signed [31:0] z_value;
	logic signed [31:0] a_value;
	logic signed [31:0] b_value;
	logic signed [31:0] c_value;
	logic signed [31:0] feed_value;
	logic [6:0]         present_mask;

	int mismatches;
	int lines_waiting;
	int lines_checked;
	int valid_lines;
	int sent;
	int lines_sent;
	int burst_left;
	int hold_asks;
	int hold_served;

	gcode_line_field_parser_core dut (.*);

	gcode_line_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	// receiver: stall level changes in stretches, level zero never stalls
	initial begin
		int stall_level;
		int level_left;
		out_stall   = 1'b0;
		hold_served = 0;
		stall_level = 0;
		level_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_served < hold_asks) begin
				hold_served++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				if (level_left == 0) begin
					stall_level = $urandom_range(0, 7);
					level_left  = $urandom_range(8, 64);
				end
				level_left--;
				out_stall <= ($urandom_range(0, 7) < stall_level);
			end
		end
	end

	// one request, sent in bursts with random gaps between them
	task automatic offer(input logic eol, input logic [7:0] ch);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				in_valid  <= 1'b0;
				cmd       <= 1'($urandom);
				char_code <= 8'($urandom);
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		cmd       <= eol;
		char_code <= ch;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
	endtask

	task automatic close_line();
		offer(1'b1, 8'($urandom));
		lines_sent++;
	endtask

	task automatic send_line(input string s);
		for (int i = 0; i < s.len(); i++)
			offer(1'b0, s[i]);
		close_line();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (lines_waiting == 0);
		@(negedge clk);
	endtask

	// result side held off long enough that an end of line backs up into the input
	task automatic squeeze();
		drain();
		hold_asks++;
		repeat (6) send_line("X1");
		drain();
	endtask

	function automatic logic [7:0] digit_char();
		return 8'(CH_0 + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] blank_char();
		return $urandom_range(0, 1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(0, 4));
	endfunction

	task automatic command_word();
		int n;
		case ($urandom_range(0, 3))
			0:       offer(1'b0, CH_G);
			1:       offer(1'b0, CH_G_LC);
			2:       offer(1'b0, CH_M);
			default: offer(1'b0, CH_M_LC);
		endcase
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
		repeat (n) offer(1'b0, digit_char());
	endtask

	task automatic axis_word();
		int n;
		if ($urandom_range(0, 7) == 0)
			offer(1'b0, AXIS_KEY[$urandom_range(0, NUM_WORDS - 1)] | 8'h20);
		else
			offer(1'b0, AXIS_KEY[$urandom_range(0, NUM_WORDS - 1)]);
		if ($urandom_range(0, 9) == 0)
			return;
		if ($urandom_range(0, 2) == 0)
			offer(1'b0, CH_MINUS);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
		repeat (n) offer(1'b0, digit_char());
		if ($urandom_range(0, 1)) begin
			offer(1'b0, CH_DOT);
			repeat ($urandom_range(0, 6)) offer(1'b0, digit_char());
		end
		if ($urandom_range(0, 7) == 0) begin
			offer(1'b0, $urandom_range(0, 1) ? CH_DOT : CH_MINUS);
			offer(1'b0, digit_char());
		end
	endtask

	task automatic random_line();
		int shape;
		shape = $urandom_range(0, 19);
		if (shape == 0) begin
			repeat ($urandom_range(0, 3)) offer(1'b0, blank_char());
		end else if (shape == 1) begin
			repeat ($urandom_range(0, 2)) offer(1'b0, blank_char());
			offer(1'b0, CH_SEMI);
			repeat ($urandom_range(0, 6))
				offer(1'b0, $urandom_range(0, 1) ? AXIS_KEY[$urandom_range(0, NUM_WORDS - 1)]
					: digit_char());
		end else if (shape <= 3) begin
			repeat ($urandom_range(1, 12)) offer(1'b0, 8'($urandom));
		end else begin
			if ($urandom_range(0, 3) == 0)
				offer(1'b0, blank_char());
			if ($urandom_range(0, 3) != 0)
				command_word();
			repeat ($urandom_range(0, 5)) begin
				axis_word();
				if ($urandom_range(0, 1))
					offer(1'b0, blank_char());
				else if ($urandom_range(0, 7) == 0)
					offer(1'b0, 8'($urandom));
			end
			if ($urandom_range(0, 5) == 0)
				command_word();
		end
		close_line();
	endtask

	initial begin
		logic mid_done;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = 1'b0;
		char_code  = '0;
		sent       = 0;
		lines_sent = 0;
		burst_left = 0;
		hold_asks  = 0;
		mid_done   = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_line("");
		send_line(" \t\n\013\014\015");
		send_line(" ;G1X5");
		send_line("G1X1.5Y-2.25Z.A-B C0.0009F12.3456");
		send_line("m65536X99999999Y-3000000Z7.8.9A1-2");
		send_line("GM5g x1X2X3");
		send_line("X-2147483.647");

		squeeze();

		while (sent < TARGET_REQUESTS || lines_sent < TARGET_LINES) begin
			random_line();
			if (!mid_done && sent >= TARGET_REQUESTS / 2) begin
				mid_done = 1'b1;
				squeeze();
			end
		end

		in_valid <= 1'b0;
		wait (lines_waiting == 0);
		repeat (10) @(posedge clk);
		$display("covered %0d requests in %0d lines, %0d results checked (%0d valid lines)",
			sent, lines_sent, lines_checked, valid_lines);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/glp_pkg.sv
design/glp_word_bank.sv
design/gcode_line_field_parser_core.sv
tb/gcode_line_checker.sv
tb/tb.sv
